@@ hw/rtl/qslerp_pkg.sv @@
// Shared types, widths and constants of the quaternion slerp pipeline.
`timescale 1ns / 1ps

package qslerp_pkg;

  localparam int COMP_W  = 16;
  localparam int NCOMP_W = 17;
  localparam int TOL_W   = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = 10'd16;

  // Dot product magnitude and sine, both unsigned Q.28 in [0, 1].
  localparam int DOT_W = 29;
  localparam int RAD_W = 57;
  localparam logic [DOT_W-1:0] ONE_Q28   = 29'd268435456;
  localparam logic [DOT_W-1:0] DOT_CLAMP = 29'd268435188;
  localparam logic [2*DOT_W-1:0] UNIT_SQ = (2*DOT_W)'(1) << 56;

  // CORDIC datapath.
  localparam int XY_W = 32;
  localparam int ANG_W = 36;
  localparam int CORDIC_STEPS = 28;
  localparam logic signed [XY_W-1:0] GAIN_INV = 32'sd163008219;
  localparam logic signed [ANG_W-1:0] HALF_PI = 36'sd421657428;
  localparam logic signed [ANG_W-1:0] PI_Q28  = 36'sd843314857;

  // Weight division and blend.
  localparam int WNUM_W = 60;
  localparam int WQ_W   = 31;
  localparam int W_W    = 33;
  localparam int V_W    = 31;
  localparam int SUM_W  = 61;
  localparam int NORM_W = 31;
  localparam int ONUM_W = 45;
  localparam int OQ_W   = 15;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [NCOMP_W-1:0] ncomp_t;
  typedef logic signed [V_W-1:0]     vcomp_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] first_x;
    logic signed [COMP_W-1:0] first_y;
    logic signed [COMP_W-1:0] first_z;
    logic signed [COMP_W-1:0] first_w;
    logic signed [COMP_W-1:0] second_x;
    logic signed [COMP_W-1:0] second_y;
    logic signed [COMP_W-1:0] second_z;
    logic signed [COMP_W-1:0] second_w;
    logic signed [COMP_W-1:0] blend;
  } item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
    logic                     took_first;
  } result_t;

  // Context carried through the angle and weight half of the pipeline.
  typedef struct packed {
    logic              took;
    comp_t             blend;
    comp_t [3:0]       a;
    ncomp_t [3:0]      b;
    logic [DOT_W-1:0]  dot;
    logic [DOT_W-1:0]  sine;
  } front_t;

  typedef struct packed {
    front_t     ctx;
    logic [1:0] ovf;
    logic [1:0] neg;
  } wside_t;

  typedef struct packed {
    logic         took;
    logic         zero;
    comp_t [3:0]  a;
    vcomp_t [3:0] v;
  } back_t;

  typedef struct packed {
    logic        took;
    logic        zero;
    comp_t [3:0] a;
    logic [3:0]  neg;
  } tail_t;

  // atan(2^-i) in Q.28; beyond the table the angle equals 2^-i.
  function automatic logic signed [ANG_W-1:0] step_angle(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 36'sd210828714;
      1: r = 36'sd124459457;
      2: r = 36'sd65760959;
      3: r = 36'sd33381290;
      4: r = 36'sd16755422;
      5: r = 36'sd8385879;
      6: r = 36'sd4193963;
      7: r = 36'sd2097109;
      8: r = 36'sd1048571;
      9: r = 36'sd524287;
      default: r = ANG_W'(1) << (28 - i);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/qslerp_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module qslerp_isqrt #(
  parameter int IN_W   = qslerp_pkg::RAD_W,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic [IN_W-1:0]          radicand,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     valid_out,
  output logic [(IN_W+1)/2-1:0]    root,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int ROOT_W = (IN_W + 1) / 2;
  localparam int RW = IN_W + 2;

  logic              vld  [0:ROOT_W];
  logic [RW-1:0]     rem  [0:ROOT_W];
  logic [ROOT_W-1:0] q    [0:ROOT_W];
  logic [SIDE_W-1:0] sd   [0:ROOT_W];

  assign vld[0] = valid_in;
  assign rem[0] = RW'(radicand);
  assign q[0]   = '0;
  assign sd[0]  = side_in;

  // The remainder holds radicand minus the square of the partial root.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [RW-1:0] term;
    logic          fit;

    assign term = (RW'(q[i]) << (K + 1)) + (RW'(1) << (2 * K));
    assign fit  = rem[i] >= term;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= fit ? rem[i] - term : rem[i];
        q[i+1]   <= fit ? (q[i] | (ROOT_W'(1) << K)) : q[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign valid_out = vld[ROOT_W];
  assign root      = q[ROOT_W];
  assign side_out  = sd[ROOT_W];

endmodule

@@ hw/rtl/qslerp_cordic_vec.sv @@
// Pipelined CORDIC in vectoring mode: angle of a first-quadrant vector.
`timescale 1ns / 1ps

module qslerp_cordic_vec #(
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 valid_in,
  input  logic signed [qslerp_pkg::XY_W-1:0]   x_in,
  input  logic signed [qslerp_pkg::XY_W-1:0]   y_in,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 valid_out,
  output logic signed [qslerp_pkg::ANG_W-1:0]  angle,
  output logic [SIDE_W-1:0]                    side_out
);

  import qslerp_pkg::*;

  logic                    vld [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  x   [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  y   [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z   [0:CORDIC_STEPS];
  logic [SIDE_W-1:0]       sd  [0:CORDIC_STEPS];

  assign vld[0] = valid_in;
  assign x[0]   = x_in;
  assign y[0]   = y_in;
  assign z[0]   = '0;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y[i][XY_W-1]) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + step_angle(i);
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - step_angle(i);
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  assign valid_out = vld[CORDIC_STEPS];
  assign angle     = z[CORDIC_STEPS];
  assign side_out  = sd[CORDIC_STEPS];

endmodule

@@ hw/rtl/qslerp_cordic_rot.sv @@
// Pipelined CORDIC in rotation mode: sine of a folded angle.
`timescale 1ns / 1ps

module qslerp_cordic_rot #(
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 valid_in,
  input  logic signed [qslerp_pkg::ANG_W-1:0]  angle,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 valid_out,
  output logic signed [qslerp_pkg::XY_W-1:0]   sine,
  output logic [SIDE_W-1:0]                    side_out
);

  import qslerp_pkg::*;

  logic                    vld [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  x   [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  y   [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z   [0:CORDIC_STEPS];
  logic [SIDE_W-1:0]       sd  [0:CORDIC_STEPS];

  // Start on the x axis with the inverse gain so y ends as the plain sine.
  assign vld[0] = valid_in;
  assign x[0]   = GAIN_INV;
  assign y[0]   = '0;
  assign z[0]   = angle;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ANG_W-1]) begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - step_angle(i);
        end else begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + step_angle(i);
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  assign valid_out = vld[CORDIC_STEPS];
  assign sine      = y[CORDIC_STEPS];
  assign side_out  = sd[CORDIC_STEPS];

endmodule

@@ hw/rtl/qslerp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module qslerp_div #(
  parameter int NUM_W  = qslerp_pkg::WNUM_W,
  parameter int DEN_W  = qslerp_pkg::DOT_W,
  parameter int Q_W    = qslerp_pkg::WQ_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] side_out
);

  // The quotient must fit in Q_W bits; the caller catches overflow.
  localparam int CW = NUM_W + DEN_W;

  logic              vld [0:Q_W];
  logic [NUM_W-1:0]  rem [0:Q_W];
  logic [DEN_W-1:0]  dv  [0:Q_W];
  logic [Q_W-1:0]    q   [0:Q_W];
  logic [SIDE_W-1:0] sd  [0:Q_W];

  assign vld[0] = valid_in;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic [CW-1:0] sh;
    logic          fit;

    assign sh  = CW'(dv[i]) << K;
    assign fit = CW'(rem[i]) >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= fit ? NUM_W'(CW'(rem[i]) - sh) : rem[i];
        q[i+1]   <= fit ? (q[i] | (Q_W'(1) << K)) : q[i];
        dv[i+1]  <= dv[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign valid_out = vld[Q_W];
  assign quot      = q[Q_W];
  assign side_out  = sd[Q_W];

endmodule

@@ hw/rtl/quaternion_slerp_unit.sv @@
// Top level of the fixed-point quaternion slerp pipeline.
// Throughput: one word per cycle while the output is not stalled; the depth is
// set by the two square roots, the CORDIC chains and the bit-per-stage dividers.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears every valid bit and sets the equality tolerance to 16.
`timescale 1ns / 1ps

module quaternion_slerp_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qslerp_pkg::TOL_W-1:0]      cfg_wdata,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  qslerp_pkg::item_t                 item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output qslerp_pkg::result_t               result
);

  import qslerp_pkg::*;

  logic             en;
  logic [TOL_W-1:0] tol;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // ---------------- Stage 1: products and equality test ----------------
  comp_t             qa [0:3];
  comp_t             qb [0:3];
  logic [NCOMP_W-1:0] diff [0:3];
  logic [NCOMP_W-1:0] adiff [0:3];
  logic              eq_next;

  logic                s1_vld;
  logic                s1_eq;
  comp_t               s1_t;
  comp_t               s1_a [0:3];
  comp_t               s1_b [0:3];
  logic signed [31:0]  s1_p [0:3];

  always_comb begin
    qa[0] = item.first_x;  qa[1] = item.first_y;
    qa[2] = item.first_z;  qa[3] = item.first_w;
    qb[0] = item.second_x; qb[1] = item.second_y;
    qb[2] = item.second_z; qb[3] = item.second_w;
    eq_next = 1'b1;
    for (int i = 0; i < 4; i++) begin
      diff[i]  = {qa[i][COMP_W-1], qa[i]} - {qb[i][COMP_W-1], qb[i]};
      adiff[i] = diff[i][NCOMP_W-1] ? -diff[i] : diff[i];
      if (adiff[i] > NCOMP_W'(tol)) begin
        eq_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_eq <= eq_next;
      s1_t  <= item.blend;
      for (int i = 0; i < 4; i++) begin
        s1_a[i] <= qa[i];
        s1_b[i] <= qb[i];
        s1_p[i] <= qa[i] * qb[i];
      end
    end
  end

  // ---------------- Stage 2: dot product, sign fold, clamp ----------------
  logic signed [34:0] dsum;
  logic [34:0]        dmag;
  logic               dneg;
  front_t             ctx2_next;

  logic   s2_vld;
  front_t s2_ctx;

  always_comb begin
    dsum = s1_p[0] + s1_p[1] + s1_p[2] + s1_p[3];
    dneg = dsum[34];
    dmag = dneg ? -dsum : dsum;
    ctx2_next       = '0;
    ctx2_next.took  = s1_eq;
    ctx2_next.blend = s1_t;
    ctx2_next.dot   = (dmag > 35'(ONE_Q28)) ? DOT_CLAMP : dmag[DOT_W-1:0];
    for (int i = 0; i < 4; i++) begin
      ctx2_next.a[i] = s1_a[i];
      ctx2_next.b[i] = dneg ? -$signed({s1_b[i][COMP_W-1], s1_b[i]})
                            : $signed({s1_b[i][COMP_W-1], s1_b[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctx <= ctx2_next;
    end
  end

  // ---------------- Stage 3: 1 - dot^2 ----------------
  logic [2*DOT_W-1:0] dsq;
  logic               s3_vld;
  logic [RAD_W-1:0]   s3_rad;
  front_t             s3_ctx;

  assign dsq = s2_ctx.dot * s2_ctx.dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad <= RAD_W'(UNIT_SQ - dsq);
      s3_ctx <= s2_ctx;
    end
  end

  // ---------------- Sine of theta by square root ----------------
  logic             sq_vld;
  logic [DOT_W-1:0] sq_root;
  front_t           sq_ctx;
  front_t           vec_in_ctx;

  qslerp_isqrt #(
    .IN_W   (RAD_W),
    .SIDE_W ($bits(front_t))
  ) u_sine_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s3_vld),
    .radicand  (s3_rad),
    .side_in   (s3_ctx),
    .valid_out (sq_vld),
    .root      (sq_root),
    .side_out  (sq_ctx)
  );

  always_comb begin
    vec_in_ctx      = sq_ctx;
    vec_in_ctx.sine = sq_root;
  end

  // ---------------- Theta by CORDIC vectoring ----------------
  logic                    vec_vld;
  logic signed [ANG_W-1:0] theta;
  front_t                  vec_ctx;

  qslerp_cordic_vec #(
    .SIDE_W ($bits(front_t))
  ) u_theta (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (sq_vld),
    .x_in      (XY_W'(sq_ctx.dot)),
    .y_in      (XY_W'(sq_root)),
    .side_in   (vec_in_ctx),
    .valid_out (vec_vld),
    .angle     (theta),
    .side_out  (vec_ctx)
  );

  // ---------------- Stage 4: scaled angles ----------------
  logic signed [NCOMP_W-1:0] u4;
  logic signed [NCOMP_W-1:0] t4;
  logic signed [48:0]        pu4;
  logic signed [48:0]        pt4;

  logic                    s4_vld;
  logic signed [ANG_W-1:0] s4_ang1;
  logic signed [ANG_W-1:0] s4_ang2;
  front_t                  s4_ctx;

  always_comb begin
    t4  = $signed({vec_ctx.blend[COMP_W-1], vec_ctx.blend});
    u4  = 17'sd16384 - t4;
    pu4 = u4 * $signed(theta[XY_W-1:0]);
    pt4 = t4 * $signed(theta[XY_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= vec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ang1 <= ANG_W'(pu4 >>> 14);
      s4_ang2 <= ANG_W'(pt4 >>> 14);
      s4_ctx  <= vec_ctx;
    end
  end

  // ---------------- Stage 5: fold angles into [-pi/2, pi/2] ----------------
  logic signed [ANG_W-1:0] f1;
  logic signed [ANG_W-1:0] f2;

  logic                    s5_vld;
  logic signed [ANG_W-1:0] s5_ang1;
  logic signed [ANG_W-1:0] s5_ang2;
  front_t                  s5_ctx;

  always_comb begin
    if (s4_ang1 > HALF_PI) begin
      f1 = PI_Q28 - s4_ang1;
    end else if (s4_ang1 < -HALF_PI) begin
      f1 = -PI_Q28 - s4_ang1;
    end else begin
      f1 = s4_ang1;
    end
    if (s4_ang2 > HALF_PI) begin
      f2 = PI_Q28 - s4_ang2;
    end else if (s4_ang2 < -HALF_PI) begin
      f2 = -PI_Q28 - s4_ang2;
    end else begin
      f2 = s4_ang2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ang1 <= f1;
      s5_ang2 <= f2;
      s5_ctx  <= s4_ctx;
    end
  end

  // ---------------- Two sine lanes ----------------
  logic                   rot_vld;
  logic signed [XY_W-1:0] sin1;
  logic signed [XY_W-1:0] sin2;
  front_t                 rot_ctx;

  qslerp_cordic_rot #(
    .SIDE_W ($bits(front_t))
  ) u_sin_first (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s5_vld),
    .angle     (s5_ang1),
    .side_in   (s5_ctx),
    .valid_out (rot_vld),
    .sine      (sin1),
    .side_out  (rot_ctx)
  );

  qslerp_cordic_rot #(
    .SIDE_W (1)
  ) u_sin_second (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s5_vld),
    .angle     (s5_ang2),
    .side_in   (1'b0),
    .valid_out (),
    .sine      (sin2),
    .side_out  ()
  );

  // ---------------- Stage 6: divider operands ----------------
  logic [XY_W-1:0] smag1;
  logic [XY_W-1:0] smag2;

  logic              s6_vld;
  logic [WNUM_W-1:0] s6_num1;
  logic [WNUM_W-1:0] s6_num2;
  wside_t            s6_side;

  always_comb begin
    smag1 = sin1[XY_W-1] ? -sin1 : sin1;
    smag2 = sin2[XY_W-1] ? -sin2 : sin2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= rot_vld;
    end
  end

  // A quotient of 2^31 or more saturates, which is |sine| >= 8 * S.
  always_ff @(posedge clk) begin
    if (en) begin
      s6_num1     <= {smag1, 28'd0};
      s6_num2     <= {smag2, 28'd0};
      s6_side.ctx <= rot_ctx;
      s6_side.ovf <= {({1'b0, smag2} >= {1'b0, rot_ctx.sine, 3'b000}),
                      ({1'b0, smag1} >= {1'b0, rot_ctx.sine, 3'b000})};
      s6_side.neg <= {sin2[XY_W-1], sin1[XY_W-1]};
    end
  end

  // ---------------- Weight dividers ----------------
  logic            wd_vld;
  logic [WQ_W-1:0] wq1;
  logic [WQ_W-1:0] wq2;
  wside_t          wd_side;

  qslerp_div #(
    .NUM_W  (WNUM_W),
    .DEN_W  (DOT_W),
    .Q_W    (WQ_W),
    .SIDE_W ($bits(wside_t))
  ) u_wdiv_first (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s6_vld),
    .num       (s6_num1),
    .den       (s6_side.ctx.sine),
    .side_in   (s6_side),
    .valid_out (wd_vld),
    .quot      (wq1),
    .side_out  (wd_side)
  );

  qslerp_div #(
    .NUM_W  (WNUM_W),
    .DEN_W  (DOT_W),
    .Q_W    (WQ_W),
    .SIDE_W (1)
  ) u_wdiv_second (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s6_vld),
    .num       (s6_num2),
    .den       (s6_side.ctx.sine),
    .side_in   (1'b0),
    .valid_out (),
    .quot      (wq2),
    .side_out  ()
  );

  // ---------------- Stage 7: weights ----------------
  logic signed [NCOMP_W-1:0] t7;
  logic signed [NCOMP_W-1:0] u7;
  logic [W_W-1:0]            wm1;
  logic [W_W-1:0]            wm2;
  logic signed [W_W-1:0]     w1_next;
  logic signed [W_W-1:0]     w2_next;

  logic                  s7_vld;
  logic signed [W_W-1:0] s7_w1;
  logic signed [W_W-1:0] s7_w2;
  front_t                s7_ctx;

  always_comb begin
    t7  = $signed({wd_side.ctx.blend[COMP_W-1], wd_side.ctx.blend});
    u7  = 17'sd16384 - t7;
    wm1 = wd_side.ovf[0] ? (W_W'(1) << 31) : W_W'(wq1);
    wm2 = wd_side.ovf[1] ? (W_W'(1) << 31) : W_W'(wq2);
    // Zero sine falls back to linear weights.
    if (wd_side.ctx.sine == '0) begin
      w1_next = W_W'(u7) <<< 14;
      w2_next = W_W'(t7) <<< 14;
    end else begin
      w1_next = wd_side.neg[0] ? -wm1 : wm1;
      w2_next = wd_side.neg[1] ? -wm2 : wm2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= wd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_w1  <= w1_next;
      s7_w2  <= w2_next;
      s7_ctx <= wd_side.ctx;
    end
  end

  // ---------------- Stage 8: weighted components ----------------
  logic               s8_vld;
  logic signed [49:0] s8_m1 [0:3];
  logic signed [49:0] s8_m2 [0:3];
  logic               s8_took;
  comp_t [3:0]        s8_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (en) begin
      s8_vld <= s7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s8_m1[i] <= s7_w1 * $signed(s7_ctx.a[i]);
        s8_m2[i] <= s7_w2 * $signed(s7_ctx.b[i]);
      end
      s8_took <= s7_ctx.took;
      s8_a    <= s7_ctx.a;
    end
  end

  // ---------------- Stage 9: blend sum, reduce to Q.24 ----------------
  logic signed [50:0] r9 [0:3];
  logic               s9_vld;
  vcomp_t             s9_v [0:3];
  logic               s9_took;
  comp_t [3:0]        s9_a;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r9[i] = s8_m1[i] + s8_m2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (en) begin
      s9_vld <= s8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s9_v[i] <= V_W'(r9[i] >>> 18);
      end
      s9_took <= s8_took;
      s9_a    <= s8_a;
    end
  end

  // ---------------- Stage 10: squares ----------------
  logic              s10_vld;
  logic [SUM_W-2:0]  s10_sq [0:3];
  vcomp_t            s10_v [0:3];
  logic              s10_took;
  comp_t [3:0]       s10_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else if (en) begin
      s10_vld <= s9_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s10_sq[i] <= s9_v[i] * s9_v[i];
        s10_v[i]  <= s9_v[i];
      end
      s10_took <= s9_took;
      s10_a    <= s9_a;
    end
  end

  // ---------------- Stage 11: length squared ----------------
  logic [SUM_W-1:0] sum11;
  back_t            back11;

  logic             s11_vld;
  logic [SUM_W-1:0] s11_sum;
  back_t            s11_back;

  always_comb begin
    sum11 = SUM_W'(s10_sq[0]) + SUM_W'(s10_sq[1]) + SUM_W'(s10_sq[2])
          + SUM_W'(s10_sq[3]);
    back11.took = s10_took;
    back11.zero = (sum11 == '0);
    back11.a    = s10_a;
    for (int i = 0; i < 4; i++) begin
      back11.v[i] = s10_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_vld <= 1'b0;
    end else if (en) begin
      s11_vld <= s10_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_sum  <= sum11;
      s11_back <= back11;
    end
  end

  // ---------------- Norm by square root ----------------
  logic              nm_vld;
  logic [NORM_W-1:0] norm;
  back_t             nm_back;

  qslerp_isqrt #(
    .IN_W   (SUM_W),
    .SIDE_W ($bits(back_t))
  ) u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s11_vld),
    .radicand  (s11_sum),
    .side_in   (s11_back),
    .valid_out (nm_vld),
    .root      (norm),
    .side_out  (nm_back)
  );

  // ---------------- Stage 12: rounded division operands ----------------
  logic [V_W-1:0]    vabs [0:3];
  logic              s12_vld;
  logic [ONUM_W-1:0] s12_num [0:3];
  logic [NORM_W-1:0] s12_norm;
  tail_t             s12_tail;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vabs[i] = nm_back.v[i][V_W-1] ? -nm_back.v[i] : nm_back.v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_vld <= 1'b0;
    end else if (en) begin
      s12_vld <= nm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s12_num[i]      <= {vabs[i][V_W-2:0], 14'd0} + ONUM_W'(norm >> 1);
        s12_tail.neg[i] <= nm_back.v[i][V_W-1];
      end
      s12_norm      <= norm;
      s12_tail.took <= nm_back.took;
      s12_tail.zero <= nm_back.zero;
      s12_tail.a    <= nm_back.a;
    end
  end

  // ---------------- Output dividers ----------------
  logic            od_vld;
  logic [OQ_W-1:0] oq [0:3];
  tail_t           od_tail;

  qslerp_div #(
    .NUM_W  (ONUM_W),
    .DEN_W  (NORM_W),
    .Q_W    (OQ_W),
    .SIDE_W ($bits(tail_t))
  ) u_odiv_lane0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s12_vld),
    .num       (s12_num[0]),
    .den       (s12_norm),
    .side_in   (s12_tail),
    .valid_out (od_vld),
    .quot      (oq[0]),
    .side_out  (od_tail)
  );

  for (genvar g = 1; g < 4; g++) begin : g_odiv
    qslerp_div #(
      .NUM_W  (ONUM_W),
      .DEN_W  (NORM_W),
      .Q_W    (OQ_W),
      .SIDE_W (1)
    ) u_odiv (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (s12_vld),
      .num       (s12_num[g]),
      .den       (s12_norm),
      .side_in   (1'b0),
      .valid_out (),
      .quot      (oq[g]),
      .side_out  ()
    );
  end

  // ---------------- Stage 13: output register ----------------
  // A zero-length blend only arises from r in [0, 2^18), which rounds to zero.
  comp_t ov [0:3];
  comp_t qv [0:3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qv[i] = COMP_W'(oq[i]);
      if (od_tail.took) begin
        ov[i] = od_tail.a[i];
      end else if (od_tail.zero) begin
        ov[i] = '0;
      end else begin
        ov[i] = od_tail.neg[i] ? -qv[i] : qv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= od_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_x      <= ov[0];
      result.out_y      <= ov[1];
      result.out_z      <= ov[2];
      result.out_w      <= ov[3];
      result.took_first <= od_tail.took;
    end
  end

endmodule
